>>> rtl/tfs_pkg.sv
`default_nettype none

package tfs_pkg;

  // Number of slots held in the cell row.
  localparam int unsigned MaxEntries = 128;
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned LimW = (CntW > 8) ? CntW : 8;

  localparam logic [7:0] FocusResetLimit = 8'd100;

  localparam logic ReqOffer  = 1'b0;
  localparam logic ReqRemove = 1'b1;

  typedef enum logic [2:0] {
    OutRejected = 3'd0,
    OutUpdated  = 3'd1,
    OutInserted = 3'd2,
    OutReplaced = 3'd3,
    OutRemoved  = 3'd4,
    OutMiss     = 3'd5
  } outcome_e;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        item_handle;
    logic signed [15:0] item_importance;
  } tfs_in_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic               was_member;
    logic [31:0]        evicted_handle;
    logic signed [15:0] evicted_importance;
    logic [7:0]         member_count;
  } tfs_out_t;

  // Running search result that walks down the cell row, one cell a cycle.
  typedef struct packed {
    logic               active;
    logic [IdxW-1:0]    idx;
    logic               hit;
    logic [IdxW-1:0]    hit_idx;
    logic               free;
    logic [IdxW-1:0]    free_idx;
    logic               min_ok;
    logic [IdxW-1:0]    min_idx;
    logic signed [15:0] min_imp;
    logic [31:0]        min_handle;
  } tfs_scan_t;

  // Write command to one slot.
  typedef struct packed {
    logic            load;
    logic            clear;
    logic [IdxW-1:0] idx;
  } tfs_wr_t;

endpackage

`default_nettype wire

>>> rtl/tfs_cell.sv
`default_nettype none

module tfs_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tfs_pkg::tfs_scan_t scan_i,
  output tfs_pkg::tfs_scan_t      scan_o,
  input  wire logic [31:0]        req_handle_i,
  input  wire logic signed [15:0] req_importance_i,
  input  wire logic               load_i,
  input  wire logic               clear_i
);

  logic [31:0]        handle_q;
  logic signed [15:0] imp_q;
  logic               valid_q;
  tfs_pkg::tfs_scan_t scan_d, scan_q;

  always_comb begin
    scan_d     = scan_i;
    scan_d.idx = scan_i.idx + 1'b1;
    if (!scan_i.hit && valid_q && (handle_q == req_handle_i)) begin
      scan_d.hit     = 1'b1;
      scan_d.hit_idx = scan_i.idx;
    end
    if (!scan_i.free && !valid_q) begin
      scan_d.free     = 1'b1;
      scan_d.free_idx = scan_i.idx;
    end
    // strict compare keeps the lowest slot among equal minima
    if (valid_q && (!scan_i.min_ok || (imp_q < scan_i.min_imp))) begin
      scan_d.min_ok     = 1'b1;
      scan_d.min_idx    = scan_i.idx;
      scan_d.min_imp    = imp_q;
      scan_d.min_handle = handle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      scan_q <= scan_d;
      if (load_i) begin
        valid_q <= 1'b1;
      end else if (clear_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      handle_q <= req_handle_i;
      imp_q    <= req_importance_i;
    end
  end

  assign scan_o = scan_q;

endmodule

`default_nettype wire

>>> rtl/tfs_chain.sv
`default_nettype none

module tfs_chain (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               scan_start_i,
  input  wire logic [31:0]        req_handle_i,
  input  wire logic signed [15:0] req_importance_i,
  input  wire tfs_pkg::tfs_wr_t   wr_i,
  output tfs_pkg::tfs_scan_t      scan_o
);

  tfs_pkg::tfs_scan_t link [tfs_pkg::MaxEntries + 1];
  logic [tfs_pkg::MaxEntries-1:0] load_vec, clear_vec;

  always_comb begin
    link[0]        = '0;
    link[0].active = scan_start_i;
  end

  // decode the slot write to one-hot enables
  always_comb begin
    load_vec  = '0;
    clear_vec = '0;
    load_vec[wr_i.idx]  = wr_i.load;
    clear_vec[wr_i.idx] = wr_i.clear;
  end

  for (genvar g = 0; g < tfs_pkg::MaxEntries; g++) begin : g_cell
    tfs_cell u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .scan_i          (link[g]),
      .scan_o          (link[g+1]),
      .req_handle_i    (req_handle_i),
      .req_importance_i(req_importance_i),
      .load_i          (load_vec[g]),
      .clear_i         (clear_vec[g])
    );
  end

  assign scan_o = link[tfs_pkg::MaxEntries];

endmodule

`default_nettype wire

>>> rtl/top_k_focus_set_top.sv
// Top-K focus set: a bounded set of (handle, importance) entries.
// Input channel in_valid_i / in_ready_o carries one request word: offer
// (insert or update importance) or remove by handle. Output channel
// out_valid_o / out_ready_i returns exactly one result word per request.
// Config channel cfg_valid_i / cfg_ready_o writes max_focus_size; write it
// only while no request is in flight.
// Slots live in a row of cells. A search token enters the first cell in the
// cycle after a request is taken and moves one cell a cycle, collecting the
// handle match, the lowest free slot and the lowest-slot minimum. The search
// result is registered once the token leaves the last cell. One request is
// in flight at a time, so a new request is taken only after the decision on
// the last one has been registered.
// The result sits in an output register; while the receiver stalls the
// block still takes the next request and scans it, then holds the finished
// decision until the output register frees up.
// Reset clears all slot valid bits, the member count and the output valid,
// and sets max_focus_size to 100. Slot contents are not cleared.
`default_nettype none

module top_k_focus_set_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire tfs_pkg::tfs_in_t in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output tfs_pkg::tfs_out_t out_word_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  localparam int unsigned CntW = tfs_pkg::CntW;
  localparam int unsigned LimW = tfs_pkg::LimW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               start_q;
  tfs_pkg::tfs_in_t   req_q;
  tfs_pkg::tfs_scan_t scan_out, tok_q;
  logic [7:0]         max_focus_q;
  logic [CntW-1:0]    held_count_q, held_count_d;
  logic               out_valid_q;
  tfs_pkg::tfs_out_t  out_word_q, res_d;
  tfs_pkg::tfs_wr_t   wr;
  logic               in_fire, done_fire, below_limit;
  logic [LimW-1:0]    cnt_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign done_fire   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  tfs_chain u_chain (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .scan_start_i    (start_q),
    .req_handle_i    (req_q.item_handle),
    .req_importance_i(req_q.item_importance),
    .wr_i            (wr),
    .scan_o          (scan_out)
  );

  // effective limit is min(max_focus_size, slot count)
  assign below_limit = (LimW'(held_count_q) < LimW'(max_focus_q)) &&
                       (held_count_q < CntW'(tfs_pkg::MaxEntries));

  // decide the request from the collected search result
  always_comb begin
    wr           = '0;
    held_count_d = held_count_q;
    res_d        = '0;
    res_d.was_member = tok_q.hit;
    res_d.outcome    = tfs_pkg::OutRejected;
    if (req_q.req_type == tfs_pkg::ReqRemove) begin
      if (tok_q.hit) begin
        wr.clear      = 1'b1;
        wr.idx        = tok_q.hit_idx;
        res_d.outcome = tfs_pkg::OutRemoved;
        if (held_count_q != '0) begin
          held_count_d = held_count_q - 1'b1;
        end
      end else begin
        res_d.outcome = tfs_pkg::OutMiss;
      end
    end else if (tok_q.hit) begin
      wr.load       = 1'b1;
      wr.idx        = tok_q.hit_idx;
      res_d.outcome = tfs_pkg::OutUpdated;
    end else if (below_limit) begin
      if (tok_q.free) begin
        wr.load       = 1'b1;
        wr.idx        = tok_q.free_idx;
        held_count_d  = held_count_q + 1'b1;
        res_d.outcome = tfs_pkg::OutInserted;
      end
    end else if (tok_q.min_ok && (req_q.item_importance > tok_q.min_imp)) begin
      wr.load                  = 1'b1;
      wr.idx                   = tok_q.min_idx;
      res_d.outcome            = tfs_pkg::OutReplaced;
      res_d.evicted_handle     = tok_q.min_handle;
      res_d.evicted_importance = tok_q.min_imp;
    end
    if (!done_fire) begin
      wr.load  = 1'b0;
      wr.clear = 1'b0;
    end
    cnt_ext            = LimW'(held_count_d);
    res_d.member_count = cnt_ext[7:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_out.active) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_q      <= 1'b0;
      max_focus_q  <= tfs_pkg::FocusResetLimit;
      held_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
      if (cfg_valid_i) begin
        max_focus_q <= cfg_data_i;
      end
      if (done_fire) begin
        held_count_q <= held_count_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold request, search result and output word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_word_i;
    end
    if ((state_q == S_SCAN) && scan_out.active) begin
      tok_q <= scan_out;
    end
    if (done_fire) begin
      out_word_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a search token only leaves the row while a scan is pending
  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_out.active |-> (state_q == S_SCAN))
    else $error("search token left the row outside a scan");

  // member count never exceeds the slot count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= CntW'(tfs_pkg::MaxEntries))
    else $error("member count above slot count");

  // member count changes only when a decision retires
  a_count_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_count_q != $past(held_count_q)) |-> $past(done_fire))
    else $error("member count changed outside a retiring request");

  // a replacement always concerns a new handle
  a_replace_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.outcome == tfs_pkg::OutReplaced)) |-> !out_word_o.was_member)
    else $error("replacement reported for a member handle");

endmodule

`default_nettype wire
